[src/fir7lp_pkg.sv]
// ---------------------------------------------------------------------------
// fir7lp_pkg
// Shared types and constants for the seven-tap low-pass FIR with bypass:
// configuration register map, control bundle and coefficient reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package fir7lp_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_COEF_BITS  = 16;
    localparam int ATTEN_BITS     = 10;

    // Delay line depth (taps 1..6)
    localparam int HIST_LEN = 6;

    // Register map
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_COEF_OUTER  = 3'd0,
        REG_COEF_SECOND = 3'd1,
        REG_COEF_THIRD  = 3'd2,
        REG_COEF_CENTER = 3'd3,
        REG_BYPASS_MODE = 3'd4,
        REG_ATTENUATION = 3'd5
    } cfg_reg_t;

    // Reset values of the coefficients, Q0.16
    localparam logic [CFG_COEF_BITS-1:0] COEF_OUTER_RST  = 16'd5138;
    localparam logic [CFG_COEF_BITS-1:0] COEF_SECOND_RST = 16'd11605;
    localparam logic [CFG_COEF_BITS-1:0] COEF_THIRD_RST  = 16'd14427;
    localparam logic [CFG_COEF_BITS-1:0] COEF_CENTER_RST = 16'd18082;

    // Mode and offset controls handed to the datapath
    typedef struct packed {
        logic                  bypass;
        logic [ATTEN_BITS-1:0] attenuation;
    } fir7lp_ctrl_t;

endpackage

`default_nettype wire

[src/fir_lowpass_7tap_with_bypass_top.sv]
// ---------------------------------------------------------------------------
// fir_lowpass_7tap_with_bypass_top
// Seven-tap symmetric low-pass FIR with bypass, attenuation offset and
// saturation to the sample range, with a register write port.
// ---------------------------------------------------------------------------
// Pipeline: the edge that accepts an input transaction loads the pre-add register;
// the multiply register and then the result register follow, and the last drives m_valid.
// Throughput: one sample per cycle while m_ready holds; the four multipliers work in parallel.
// Reset (aresetn low, synchronous): delay line cleared to zero, pipeline
// emptied, coefficients back to their defaults, filter mode, zero offset.
`default_nettype none

module fir_lowpass_7tap_with_bypass_top
    import fir7lp_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int COEF_BITS   = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output      logic                      s_ready,
    input  wire logic [SAMPLE_BITS-1:0]    s_sample_in,
    output      logic                      m_valid,
    input  wire logic                      m_ready,
    output      logic [SAMPLE_BITS-1:0]    m_sample_out,
    output      logic                      m_clipped,
    input  wire logic                      cfg_valid,
    output      logic                      cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    logic [COEF_BITS-1:0] coef_outer, coef_second, coef_third, coef_center;
    fir7lp_ctrl_t         ctrl;

    // Configuration registers
    fir7lp_cfg_regs #(
        .COEF_BITS (COEF_BITS)
    ) u_cfg_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .coef_outer  (coef_outer),
        .coef_second (coef_second),
        .coef_third  (coef_third),
        .coef_center (coef_center),
        .ctrl        (ctrl)
    );

    // Filter pipeline
    fir7lp_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_clipped    (m_clipped),
        .coef_outer   (coef_outer),
        .coef_second  (coef_second),
        .coef_third   (coef_third),
        .coef_center  (coef_center),
        .ctrl         (ctrl)
    );

endmodule

`default_nettype wire

[src/fir7lp_cfg_regs.sv]
// ---------------------------------------------------------------------------
// fir7lp_cfg_regs
// Configuration register file: four coefficients, bypass mode and the
// attenuation offset, written through a valid/ready write channel.
// ---------------------------------------------------------------------------
`default_nettype none

module fir7lp_cfg_regs
    import fir7lp_pkg::*;
#(
    parameter int COEF_BITS = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_valid,
    output      logic                      cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    output      logic [COEF_BITS-1:0]      coef_outer,
    output      logic [COEF_BITS-1:0]      coef_second,
    output      logic [COEF_BITS-1:0]      coef_third,
    output      logic [COEF_BITS-1:0]      coef_center,
    output      fir7lp_ctrl_t              ctrl
);

    logic [COEF_BITS-1:0] coef_outer_reg,  coef_outer_next;
    logic [COEF_BITS-1:0] coef_second_reg, coef_second_next;
    logic [COEF_BITS-1:0] coef_third_reg,  coef_third_next;
    logic [COEF_BITS-1:0] coef_center_reg, coef_center_next;
    fir7lp_ctrl_t         ctrl_reg,        ctrl_next;
    logic [COEF_BITS-1:0] coef_wdata;

    // Every write is accepted at once; cfg_ready is tied high
    assign cfg_ready  = 1'b1;
    assign coef_wdata = COEF_BITS'(cfg_data[CFG_COEF_BITS-1:0]);

    // Decode the register index; unknown indexes are dropped
    always_comb begin
        coef_outer_next  = coef_outer_reg;
        coef_second_next = coef_second_reg;
        coef_third_next  = coef_third_reg;
        coef_center_next = coef_center_reg;
        ctrl_next        = ctrl_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COEF_OUTER:  coef_outer_next  = coef_wdata;
                REG_COEF_SECOND: coef_second_next = coef_wdata;
                REG_COEF_THIRD:  coef_third_next  = coef_wdata;
                REG_COEF_CENTER: coef_center_next = coef_wdata;
                REG_BYPASS_MODE: ctrl_next.bypass = cfg_data[0];
                REG_ATTENUATION: ctrl_next.attenuation = cfg_data[ATTEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_outer_reg   <= COEF_BITS'(COEF_OUTER_RST);
            coef_second_reg  <= COEF_BITS'(COEF_SECOND_RST);
            coef_third_reg   <= COEF_BITS'(COEF_THIRD_RST);
            coef_center_reg  <= COEF_BITS'(COEF_CENTER_RST);
            ctrl_reg         <= '0;
        end else begin
            coef_outer_reg   <= coef_outer_next;
            coef_second_reg  <= coef_second_next;
            coef_third_reg   <= coef_third_next;
            coef_center_reg  <= coef_center_next;
            ctrl_reg         <= ctrl_next;
        end
    end

    assign coef_outer  = coef_outer_reg;
    assign coef_second = coef_second_reg;
    assign coef_third  = coef_third_reg;
    assign coef_center = coef_center_reg;
    assign ctrl        = ctrl_reg;

endmodule

`default_nettype wire

[src/fir7lp_datapath.sv]
// ---------------------------------------------------------------------------
// fir7lp_datapath
// Delay line, symmetric pre-add, coefficient multiply, sum, offset and
// saturation. Three register stages with per-stage flow control.
// ---------------------------------------------------------------------------
`default_nettype none

module fir7lp_datapath
    import fir7lp_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int COEF_BITS   = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output      logic                   s_ready,
    input  wire logic [SAMPLE_BITS-1:0] s_sample_in,
    output      logic                   m_valid,
    input  wire logic                   m_ready,
    output      logic [SAMPLE_BITS-1:0] m_sample_out,
    output      logic                   m_clipped,
    input  wire logic [COEF_BITS-1:0]   coef_outer,
    input  wire logic [COEF_BITS-1:0]   coef_second,
    input  wire logic [COEF_BITS-1:0]   coef_third,
    input  wire logic [COEF_BITS-1:0]   coef_center,
    input  wire fir7lp_ctrl_t           ctrl
);

    localparam int PAIR_BITS = SAMPLE_BITS + 1;
    localparam int PROD_BITS = COEF_BITS + PAIR_BITS;
    localparam int SUM_BITS  = COEF_BITS + SAMPLE_BITS + 3;
    localparam int RAW_BITS  = SAMPLE_BITS + 3;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

    // Delay line, newest first
    logic [SAMPLE_BITS-1:0] hist_reg [HIST_LEN];

    // Stage 0: pre-added tap pairs
    logic                   v0_reg;
    logic [PAIR_BITS-1:0]   pair_outer_reg, pair_second_reg, pair_third_reg;
    logic [SAMPLE_BITS-1:0] center_reg, x0_reg;

    // Stage 1: products
    logic                   v1_reg;
    logic [PROD_BITS-1:0]   prod_outer_reg, prod_second_reg, prod_third_reg;
    logic [PROD_BITS-1:0]   prod_center_reg;
    logic [SAMPLE_BITS-1:0] x1_reg;

    // Stage 2: result
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_sample_reg, out_sample_next;
    logic                   out_clip_reg,   out_clip_next;

    logic ready1, ready2, s_take;
    logic [SUM_BITS-1:0] sum;
    logic [RAW_BITS-1:0] raw, att, diff;

    // Flow control: a stage loads when it is empty or its successor loads
    assign ready2  = !out_valid_reg || m_ready;
    assign ready1  = !v1_reg || ready2;
    assign s_ready = !v0_reg || ready1;
    assign s_take  = s_valid && s_ready;

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                v0_reg <= s_valid;
            end
            if (ready1) begin
                v1_reg <= v0_reg;
            end
            if (ready2) begin
                out_valid_reg <= v1_reg;
            end
        end
    end

    // Advance the delay line on every accepted transaction, in both modes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < HIST_LEN; k++) begin
                hist_reg[k] <= '0;
            end
        end else if (s_take) begin
            hist_reg[0] <= s_sample_in;
            for (int k = 1; k < HIST_LEN; k++) begin
                hist_reg[k] <= hist_reg[k-1];
            end
        end
    end

    // Stage 0: fold the symmetric taps
    always_ff @(posedge aclk) begin
        if (s_take) begin
            pair_outer_reg  <= PAIR_BITS'(s_sample_in) + PAIR_BITS'(hist_reg[5]);
            pair_second_reg <= PAIR_BITS'(hist_reg[0]) + PAIR_BITS'(hist_reg[4]);
            pair_third_reg  <= PAIR_BITS'(hist_reg[1]) + PAIR_BITS'(hist_reg[3]);
            center_reg      <= hist_reg[2];
            x0_reg          <= s_sample_in;
        end
    end

    // Stage 1: four multiplies
    always_ff @(posedge aclk) begin
        if (ready1 && v0_reg) begin
            prod_outer_reg  <= PROD_BITS'(coef_outer)  * PROD_BITS'(pair_outer_reg);
            prod_second_reg <= PROD_BITS'(coef_second) * PROD_BITS'(pair_second_reg);
            prod_third_reg  <= PROD_BITS'(coef_third)  * PROD_BITS'(pair_third_reg);
            prod_center_reg <= PROD_BITS'(coef_center) * PROD_BITS'(center_reg);
            x1_reg          <= x0_reg;
        end
    end

    // Stage 2: sum, truncate, subtract offset, saturate
    always_comb begin
        sum = SUM_BITS'(prod_outer_reg) + SUM_BITS'(prod_second_reg)
            + SUM_BITS'(prod_third_reg) + SUM_BITS'(prod_center_reg);
        raw = ctrl.bypass ? RAW_BITS'(x1_reg) : sum[SUM_BITS-1:COEF_BITS];
        att = RAW_BITS'(ctrl.attenuation);
        diff = raw - att;
        if (raw < att) begin
            out_sample_next = '0;
            out_clip_next   = 1'b1;
        end else if (diff[RAW_BITS-1:SAMPLE_BITS] != '0) begin
            out_sample_next = SAMPLE_MAX;
            out_clip_next   = 1'b1;
        end else begin
            out_sample_next = diff[SAMPLE_BITS-1:0];
            out_clip_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready2 && v1_reg) begin
            out_sample_reg <= out_sample_next;
            out_clip_reg   <= out_clip_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_sample_out = out_sample_reg;
    assign m_clipped    = out_clip_reg;

    // A clipped result sits at one of the two rails
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_clipped) |-> (m_sample_out == '0 || m_sample_out == SAMPLE_MAX))
        else $error("clipped result not at a rail");

    // Input stalls only when every stage holds a transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v0_reg && v1_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    // Reset leaves the pipeline empty
    assert property (@(posedge aclk)
        !aresetn |=> (!v0_reg && !v1_reg && !out_valid_reg))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
